/* design/assert_macros.svh */
// Assertion macros used by the sort engine datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* design/qsse_pkg.sv */
// Package: sizes, state and datapath op codes, and controller status for the sort engine.
`timescale 1ns / 1ps

package qsse_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W    = IDX_W + 1;
    localparam int PTR_W    = IDX_W + 2;
    localparam int STK_W    = 2 * IDX_W;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [PTR_W-1:0] ptr_t;
    typedef logic [STK_W-1:0]        stk_t;

    localparam cnt_t MAX_CNT   = CNT_W'(MAX_KEYS);
    localparam cnt_t STACK_CAP = CNT_W'(MAX_KEYS / 2);
    localparam cnt_t CNT_ONE   = CNT_W'(1);
    localparam cnt_t CNT_TWO   = CNT_W'(2);
    localparam ptr_t PTR_ONE   = PTR_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_POP,
        S_RANGE,
        S_PIVOT,
        S_SCAN_I,
        S_SCAN_J,
        S_SWAP,
        S_PUSH_HI,
        S_PUSH_LO,
        S_EMIT_START,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_POP,
        OP_RANGE,
        OP_PIVOT,
        OP_SCAN_I,
        OP_SCAN_J,
        OP_SWAP,
        OP_PUSH_HI,
        OP_PUSH_LO,
        OP_EMIT_START,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic fill_lt2;
        logic sp_zero;
        logic range_bad;
        logic scan_i_go;
        logic scan_j_go;
        logic i_le_j;
        logic swap_more;
        logic emit_last;
    } status_t;

endpackage

/* design/qsse_ram.sv */
// Generic single-write, single-read RAM with registered, write-first read.
`timescale 1ns / 1ps

module qsse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/qsse_ctrl.sv */
// Controller: sequences load, quicksort partition steps and emit for the sort engine.
`timescale 1ns / 1ps

module qsse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               last,
    input  qsse_pkg::status_t  status,
    output qsse_pkg::dp_op_t   op,
    output logic               busy,
    output logic               strobe
);

    qsse_pkg::state_t state_reg;
    qsse_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qsse_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qsse_pkg::S_IDLE:
            begin
                if (start && last)
                begin
                    state_next = qsse_pkg::S_INIT;
                end
            end
            qsse_pkg::S_INIT:
            begin
                state_next = status.fill_lt2 ? qsse_pkg::S_EMIT_START : qsse_pkg::S_POP;
            end
            qsse_pkg::S_POP:
            begin
                state_next = status.sp_zero ? qsse_pkg::S_EMIT_START : qsse_pkg::S_RANGE;
            end
            qsse_pkg::S_RANGE:
            begin
                state_next = status.range_bad ? qsse_pkg::S_POP : qsse_pkg::S_PIVOT;
            end
            qsse_pkg::S_PIVOT:
            begin
                state_next = qsse_pkg::S_SCAN_I;
            end
            qsse_pkg::S_SCAN_I:
            begin
                state_next = status.scan_i_go ? qsse_pkg::S_SCAN_I : qsse_pkg::S_SCAN_J;
            end
            qsse_pkg::S_SCAN_J:
            begin
                if (status.scan_j_go)
                begin
                    state_next = qsse_pkg::S_SCAN_J;
                end
                else if (status.i_le_j)
                begin
                    state_next = qsse_pkg::S_SWAP;
                end
                else
                begin
                    state_next = qsse_pkg::S_PUSH_HI;
                end
            end
            qsse_pkg::S_SWAP:
            begin
                state_next = status.swap_more ? qsse_pkg::S_SCAN_I : qsse_pkg::S_PUSH_HI;
            end
            qsse_pkg::S_PUSH_HI:
            begin
                state_next = qsse_pkg::S_PUSH_LO;
            end
            qsse_pkg::S_PUSH_LO:
            begin
                state_next = qsse_pkg::S_POP;
            end
            qsse_pkg::S_EMIT_START:
            begin
                state_next = qsse_pkg::S_EMIT;
            end
            qsse_pkg::S_EMIT:
            begin
                if (status.emit_last)
                begin
                    state_next = qsse_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = qsse_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op     = qsse_pkg::OP_NONE;
        busy   = 1'b1;
        strobe = 1'b0;
        case (state_reg)
            qsse_pkg::S_IDLE:
            begin
                busy = 1'b0;
                op   = start ? qsse_pkg::OP_LOAD : qsse_pkg::OP_NONE;
            end
            qsse_pkg::S_INIT:       op = qsse_pkg::OP_INIT;
            qsse_pkg::S_POP:
            begin
                op = status.sp_zero ? qsse_pkg::OP_NONE : qsse_pkg::OP_POP;
            end
            qsse_pkg::S_RANGE:      op = qsse_pkg::OP_RANGE;
            qsse_pkg::S_PIVOT:      op = qsse_pkg::OP_PIVOT;
            qsse_pkg::S_SCAN_I:     op = qsse_pkg::OP_SCAN_I;
            qsse_pkg::S_SCAN_J:     op = qsse_pkg::OP_SCAN_J;
            qsse_pkg::S_SWAP:       op = qsse_pkg::OP_SWAP;
            qsse_pkg::S_PUSH_HI:    op = qsse_pkg::OP_PUSH_HI;
            qsse_pkg::S_PUSH_LO:    op = qsse_pkg::OP_PUSH_LO;
            qsse_pkg::S_EMIT_START: op = qsse_pkg::OP_EMIT_START;
            qsse_pkg::S_EMIT:
            begin
                op     = qsse_pkg::OP_EMIT;
                strobe = 1'b1;
            end
            default:
            begin
                op = qsse_pkg::OP_NONE;
            end
        endcase
    end

endmodule

/* design/qsse_datapath.sv */
// Datapath: key store, range stack, partition indices and pivot of the sort engine.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qsse_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qsse_pkg::dp_op_t         op,
    input  logic signed [31:0]       key,
    output qsse_pkg::status_t        status,
    output logic signed [31:0]       sorted_key,
    output logic                     end_of_batch,
    output logic                     overflow
);

    qsse_pkg::cnt_t fill_reg, fill_next;
    qsse_pkg::cnt_t sp_reg, sp_next;
    qsse_pkg::cnt_t k_reg, k_next;
    logic           dropped_reg, dropped_next;
    qsse_pkg::idx_t lo_reg, lo_next;
    qsse_pkg::idx_t hi_reg, hi_next;
    qsse_pkg::ptr_t i_reg, i_next;
    qsse_pkg::ptr_t j_reg, j_next;
    qsse_pkg::key_t pivot_reg, pivot_next;
    qsse_pkg::key_t ki_reg, ki_next;

    logic           key_we;
    qsse_pkg::idx_t key_waddr, key_raddr;
    qsse_pkg::key_t key_wdata, key_rdata;
    logic           stk_we;
    qsse_pkg::idx_t stk_waddr, stk_raddr;
    qsse_pkg::stk_t stk_wdata, stk_rdata;

    qsse_pkg::idx_t          stk_lo, stk_hi;
    logic [qsse_pkg::IDX_W:0] mid_sum;
    qsse_pkg::ptr_t          i_inc, j_dec, lo_ext, hi_ext;
    qsse_pkg::cnt_t          sp_dec, k_inc, fill_dec;

    qsse_ram #(.WIDTH(qsse_pkg::KEY_W), .DEPTH(qsse_pkg::MAX_KEYS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    qsse_ram #(.WIDTH(qsse_pkg::STK_W), .DEPTH(qsse_pkg::MAX_KEYS)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign stk_lo   = stk_rdata[qsse_pkg::STK_W-1:qsse_pkg::IDX_W];
    assign stk_hi   = stk_rdata[qsse_pkg::IDX_W-1:0];
    assign mid_sum  = {1'b0, stk_lo} + {1'b0, stk_hi};
    assign i_inc    = i_reg + qsse_pkg::PTR_ONE;
    assign j_dec    = j_reg - qsse_pkg::PTR_ONE;
    assign lo_ext   = qsse_pkg::ptr_t'({2'b00, lo_reg});
    assign hi_ext   = qsse_pkg::ptr_t'({2'b00, hi_reg});
    assign sp_dec   = sp_reg - qsse_pkg::CNT_ONE;
    assign k_inc    = k_reg + qsse_pkg::CNT_ONE;
    assign fill_dec = fill_reg - qsse_pkg::CNT_ONE;

    always_comb
    begin
        status.fill_lt2  = fill_reg < qsse_pkg::CNT_TWO;
        status.sp_zero   = sp_reg == '0;
        status.range_bad = ({1'b0, stk_hi} >= fill_reg) || (stk_lo >= stk_hi);
        status.scan_i_go = (i_reg < hi_ext) && (key_rdata < pivot_reg);
        status.scan_j_go = (j_reg > lo_ext) && (pivot_reg < key_rdata);
        status.i_le_j    = i_reg <= j_reg;
        status.swap_more = i_inc <= j_dec;
        status.emit_last = k_reg == fill_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            sp_reg      <= '0;
            k_reg       <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            sp_reg      <= sp_next;
            k_reg       <= k_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        pivot_reg <= pivot_next;
        ki_reg    <= ki_next;
    end

    always_comb
    begin
        fill_next    = fill_reg;
        sp_next      = sp_reg;
        k_next       = k_reg;
        dropped_next = dropped_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pivot_next   = pivot_reg;
        ki_next      = ki_reg;
        key_we       = 1'b0;
        key_waddr    = fill_reg[qsse_pkg::IDX_W-1:0];
        key_wdata    = key;
        key_raddr    = '0;
        stk_we       = 1'b0;
        stk_waddr    = sp_reg[qsse_pkg::IDX_W-1:0];
        stk_wdata    = '0;
        stk_raddr    = sp_dec[qsse_pkg::IDX_W-1:0];
        case (op)
            qsse_pkg::OP_LOAD:
            begin
                if (fill_reg < qsse_pkg::MAX_CNT)
                begin
                    key_we    = 1'b1;
                    fill_next = fill_reg + qsse_pkg::CNT_ONE;
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
            qsse_pkg::OP_INIT:
            begin
                sp_next = '0;
                if (!status.fill_lt2)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = {{qsse_pkg::IDX_W{1'b0}}, fill_dec[qsse_pkg::IDX_W-1:0]};
                    sp_next   = qsse_pkg::CNT_ONE;
                end
            end
            qsse_pkg::OP_POP:
            begin
                sp_next = sp_dec;
            end
            qsse_pkg::OP_RANGE:
            begin
                lo_next   = stk_lo;
                hi_next   = stk_hi;
                i_next    = qsse_pkg::ptr_t'({2'b00, stk_lo});
                j_next    = qsse_pkg::ptr_t'({2'b00, stk_hi});
                key_raddr = mid_sum[qsse_pkg::IDX_W:1];
            end
            qsse_pkg::OP_PIVOT:
            begin
                pivot_next = key_rdata;
                key_raddr  = i_reg[qsse_pkg::IDX_W-1:0];
            end
            qsse_pkg::OP_SCAN_I:
            begin
                if (status.scan_i_go)
                begin
                    i_next    = i_inc;
                    key_raddr = i_inc[qsse_pkg::IDX_W-1:0];
                end
                else
                begin
                    ki_next   = key_rdata;
                    key_raddr = j_reg[qsse_pkg::IDX_W-1:0];
                end
            end
            qsse_pkg::OP_SCAN_J:
            begin
                if (status.scan_j_go)
                begin
                    j_next    = j_dec;
                    key_raddr = j_dec[qsse_pkg::IDX_W-1:0];
                end
                else if (status.i_le_j)
                begin
                    key_we    = 1'b1;
                    key_waddr = i_reg[qsse_pkg::IDX_W-1:0];
                    key_wdata = key_rdata;
                end
            end
            qsse_pkg::OP_SWAP:
            begin
                // second half of the exchange; read of the next i sees it write-first
                key_we    = 1'b1;
                key_waddr = j_reg[qsse_pkg::IDX_W-1:0];
                key_wdata = ki_reg;
                i_next    = i_inc;
                j_next    = j_dec;
                key_raddr = i_inc[qsse_pkg::IDX_W-1:0];
            end
            qsse_pkg::OP_PUSH_HI:
            begin
                if ((i_reg < hi_ext) && (sp_reg < qsse_pkg::MAX_CNT))
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {i_reg[qsse_pkg::IDX_W-1:0], hi_reg};
                    sp_next   = sp_reg + qsse_pkg::CNT_ONE;
                end
            end
            qsse_pkg::OP_PUSH_LO:
            begin
                if ((lo_ext < j_reg) && (sp_reg < qsse_pkg::MAX_CNT))
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {lo_reg, j_reg[qsse_pkg::IDX_W-1:0]};
                    sp_next   = sp_reg + qsse_pkg::CNT_ONE;
                end
            end
            qsse_pkg::OP_EMIT_START:
            begin
                k_next    = '0;
                key_raddr = '0;
            end
            qsse_pkg::OP_EMIT:
            begin
                k_next    = k_inc;
                key_raddr = k_inc[qsse_pkg::IDX_W-1:0];
                if (status.emit_last)
                begin
                    fill_next    = '0;
                    sp_next      = '0;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sorted_key   = key_rdata;
    assign end_of_batch = (op == qsse_pkg::OP_EMIT) && status.emit_last;
    assign overflow     = dropped_reg;

    `ASSERT_ALWAYS(a_fill_bound, fill_reg <= qsse_pkg::MAX_CNT)
    `ASSERT_ALWAYS(a_stack_bound, sp_reg <= qsse_pkg::STACK_CAP)
    `ASSERT_IMPLIES(a_scan_i_in_range, op == qsse_pkg::OP_SCAN_I, i_reg <= hi_ext)
    `ASSERT_IMPLIES(a_emit_in_batch, op == qsse_pkg::OP_EMIT, k_reg < fill_reg)

endmodule

/* design/quicksort_sort_engine_unit.sv */
// Top level of the quicksort sort engine: controller plus datapath.
`timescale 1ns / 1ps
//
// Usage: drive key and last with start high; an item is taken at a clock edge
// where start is high and busy is low. While busy is low, keys load one per
// cycle into a 64-entry store; keys past capacity are dropped and overflow is
// set for the batch. The item with last set closes the batch and raises busy
// while the block sorts. Each partition step reads one key per cycle from the
// key RAM; each range popped off the range stack passes the pop, range and
// pivot steps before its scans and swaps, and a range that needs no work goes
// straight back to pop. The sorted keys then come out one per cycle on
// sorted_key, each marked by strobe for exactly one cycle, with end_of_batch
// on the last one and overflow held over the whole batch; busy drops the
// cycle after the final result.
// The receiver cannot stall: every strobed result is taken in its cycle.
// Reset returns the controller to idle and clears the fill count, stack depth
// and drop flag; RAM contents are not cleared.
//
module quicksort_sort_engine_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] key,
    input  logic               last,
    output logic               strobe,
    output logic signed [31:0] sorted_key,
    output logic               end_of_batch,
    output logic               overflow
);

    qsse_pkg::dp_op_t  op;
    qsse_pkg::status_t status;

    qsse_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (last),
        .status (status),
        .op     (op),
        .busy   (busy),
        .strobe (strobe)
    );

    qsse_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .key          (key),
        .status       (status),
        .sorted_key   (sorted_key),
        .end_of_batch (end_of_batch),
        .overflow     (overflow)
    );

endmodule

/* sim/quicksort_sort_engine_unit_tb.sv */
// Testbench for quicksort_sort_engine_unit: key batches in, sorted keys checked.
`timescale 1ns / 1ps

module quicksort_sort_engine_unit_tb;

    localparam int STALL_LIMIT = 50000;

    typedef struct {
        qsse_pkg::key_t k;
        logic           l;
    } key_item_t;

    typedef struct {
        qsse_pkg::key_t k;
        logic           eob;
        logic           ovf;
    } sorted_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    qsse_pkg::key_t key = '0;
    logic           last = 1'b0;
    logic           strobe;
    qsse_pkg::key_t sorted_key;
    logic           end_of_batch;
    logic           overflow;

    key_item_t      key_feed[$];
    sorted_t        sorted_due[$];
    qsse_pkg::key_t batch_keys[$];
    logic           batch_dropped = 1'b0;
    logic           item_taken = 1'b0;
    int             gap_pct = 0;
    int             mismatches = 0;
    int             keys_checked = 0;
    int             items_sent = 0;
    int             batches = 0;
    int             overflow_batches = 0;
    int             idle_cycles = 0;

    quicksort_sort_engine_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .key          (key),
        .last         (last),
        .strobe       (strobe),
        .sorted_key   (sorted_key),
        .end_of_batch (end_of_batch),
        .overflow     (overflow)
    );

    always #5 clk = ~clk;

    // Store the key if room is left; on the closing item sort and queue the batch.
    task automatic absorb_key(input qsse_pkg::key_t k, input logic l);
        qsse_pkg::key_t run[$];
        qsse_pkg::key_t t;
        int             j;
        sorted_t        s;
        begin
            if (batch_keys.size() < qsse_pkg::MAX_KEYS)
                batch_keys.push_back(k);
            else
                batch_dropped = 1'b1;
            if (l)
            begin
                run = batch_keys;
                for (int i = 1; i < run.size(); i++)
                begin
                    t = run[i];
                    j = i - 1;
                    while (j >= 0 && run[j] > t)
                    begin
                        run[j + 1] = run[j];
                        j--;
                    end
                    run[j + 1] = t;
                end
                for (int i = 0; i < run.size(); i++)
                begin
                    s.k   = run[i];
                    s.eob = (i == run.size() - 1);
                    s.ovf = batch_dropped;
                    sorted_due.push_back(s);
                end
                batch_keys.delete();
                batch_dropped = 1'b0;
            end
        end
    endtask

    function automatic qsse_pkg::key_t pick_key(input bit narrow);
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                pick_key = 32'sh7FFF_FFFF;
            else if (roll < 6)
                pick_key = 32'sh8000_0000;
            else if (narrow)
                pick_key = qsse_pkg::key_t'($urandom_range(0, 6)) - 3;
            else
                pick_key = qsse_pkg::key_t'($urandom);
        end
    endfunction

    task automatic add_batch(input qsse_pkg::key_t vals[$]);
        key_item_t it;
        begin
            for (int i = 0; i < vals.size(); i++)
            begin
                it.k = vals[i];
                it.l = (i == vals.size() - 1);
                key_feed.push_back(it);
            end
            items_sent += vals.size();
            batches++;
            if (vals.size() > qsse_pkg::MAX_KEYS)
                overflow_batches++;
        end
    endtask

    task automatic add_random_batch(input int n);
        qsse_pkg::key_t vals[$];
        bit             narrow;
        begin
            narrow = ($urandom_range(0, 99) < 30);
            repeat (n)
                vals.push_back(pick_key(narrow));
            add_batch(vals);
        end
    endtask

    task automatic fill_phase(input int target, input int big_size);
        int n;
        int sent;
        begin
            sent = 0;
            if (big_size > 0)
            begin
                add_random_batch(big_size);
                sent = big_size;
            end
            while (sent < target)
            begin
                n = ($urandom_range(0, 99) < 8) ? qsse_pkg::MAX_KEYS + $urandom_range(0, 2)
                                                : $urandom_range(1, 16);
                add_random_batch(n);
                sent += n;
            end
        end
    endtask

    task automatic drain;
        begin
            while (key_feed.size() != 0 || sorted_due.size() != 0)
                @(posedge clk);
        end
    endtask

    // Driver: holds an item until taken, idles at random between items.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !item_taken))
        begin
            if (start)
                void'(key_feed.pop_front());
            if (key_feed.size() > 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                start <= 1'b1;
                key   <= key_feed[0].k;
                last  <= key_feed[0].l;
            end
            else
            begin
                start <= 1'b0;
                key   <= qsse_pkg::key_t'($urandom);
                last  <= 1'($urandom_range(0, 1));
            end
        end
    end

    // Monitor: checks each strobed result, feeds accepted items to the predictor.
    always @(posedge clk)
    begin
        sorted_t want;
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            if (strobe)
            begin
                keys_checked++;
                if (sorted_due.size() == 0)
                begin
                    $display("%0t: unexpected result key=%0d eob=%0b ovf=%0b",
                             $time, sorted_key, end_of_batch, overflow);
                    mismatches++;
                end
                else
                begin
                    want = sorted_due.pop_front();
                    if (sorted_key !== want.k || end_of_batch !== want.eob ||
                        overflow !== want.ovf)
                    begin
                        $display("%0t: mismatch exp key=%0d eob=%0b ovf=%0b",
                                 $time, want.k, want.eob, want.ovf,
                                 " got key=%0d eob=%0b ovf=%0b",
                                 sorted_key, end_of_batch, overflow);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                absorb_key(key, last);
            item_taken <= start && !busy;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single key, two keys reversed, extremes with duplicates, all equal, presorted
        gap_pct = 15;
        add_batch('{32'sd0});
        add_batch('{32'sh7FFF_FFFF, 32'sh8000_0000});
        add_batch('{32'sh7FFF_FFFF, -32'sd1, 32'sh8000_0000, 32'sd0, 32'sd1, -32'sd1,
                    32'sh7FFF_FFFF});
        add_batch('{-32'sd5, -32'sd5, -32'sd5, -32'sd5});
        add_batch('{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2});
        fill_phase(70, qsse_pkg::MAX_KEYS + $urandom_range(1, 3));
        drain();

        gap_pct = 60;
        fill_phase(70, qsse_pkg::MAX_KEYS);
        drain();

        gap_pct = 0;
        fill_phase(45, 0);
        drain();

        repeat (40) @(posedge clk);
        $display("Sent %0d keys in %0d batches, %0d of them over capacity.",
                 items_sent, batches, overflow_batches);
        $display("Checked %0d sorted keys, %0d mismatches.", keys_checked, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
